// ===== rtl/uart_8n1_tx_rx_macros.svh =====
// ----------------------------------------------------------------------------
// UART 8N1 assertion macros
// Shorthand for clocked assertions with the block reset as disable.
// ----------------------------------------------------------------------------
`ifndef UART_8N1_TX_RX_MACROS_SVH
`define UART_8N1_TX_RX_MACROS_SVH

// same-cycle implication
`define U8TR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U8TR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/u8tr_pkg.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 package
// Shared types and constants of the transmitter and receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8tr_pkg;

	localparam logic [15:0] BIT_TIME_RESET = 16'd2500;
	localparam logic [3:0]  FRAME_BITS     = 4'd10;
	localparam logic [3:0]  TX_BITS        = 4'd9;

	typedef struct packed {
		logic       rx_line;
		logic       tx_byte_valid;
		logic [7:0] tx_byte;
		logic       rx_sink_full;
	} req_t;

	typedef struct packed {
		logic line;
		logic taken;
	} tx_res_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [7:0] no_start;
		logic [7:0] no_stop;
		logic [7:0] lost;
		logic       lost_flag;
	} rx_res_t;

	typedef struct packed {
		tx_res_t tx;
		rx_res_t rx;
	} res_t;

endpackage

// ===== rtl/u8tr_req_if.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 request channel
// One tick of line and transmit-offer inputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8tr_req_if;
	logic       valid;
	logic       ready;
	logic       rx_line;
	logic       tx_byte_valid;
	logic [7:0] tx_byte;
	logic       rx_sink_full;

	modport source (output valid, rx_line, tx_byte_valid, tx_byte, rx_sink_full,
		input ready);
	modport sink (input valid, rx_line, tx_byte_valid, tx_byte, rx_sink_full,
		output ready);
endinterface

// ===== rtl/u8tr_res_if.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 result channel
// Line level, handshake flags and receive status after one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8tr_res_if;
	logic       valid;
	logic       ready;
	logic       tx_line;
	logic       tx_byte_taken;
	logic       rx_byte_valid;
	logic [7:0] rx_byte;
	logic [7:0] no_start_count;
	logic [7:0] no_stop_count;
	logic [7:0] lost_count;
	logic       lost_flag;

	modport source (output valid, tx_line, tx_byte_taken, rx_byte_valid, rx_byte,
		no_start_count, no_stop_count, lost_count, lost_flag, input ready);
	modport sink (input valid, tx_line, tx_byte_taken, rx_byte_valid, rx_byte,
		no_start_count, no_stop_count, lost_count, lost_flag, output ready);
endinterface

// ===== rtl/u8tr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 configuration channel
// Write of the bit time register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8tr_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] bit_time;

	modport source (output valid, bit_time, input ready);
	modport sink (input valid, bit_time, output ready);
endinterface

// ===== rtl/u8tr_tx.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 transmitter
// Bit timer and frame shifter, advanced once per accepted tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8tr_tx (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [15:0]      bit_time,
	input  logic             offer,
	input  logic [7:0]       data,
	output u8tr_pkg::tx_res_t res
);
	import u8tr_pkg::*;

	logic [15:0] timer_q, timer_d;
	logic [8:0]  shift_q, shift_d;
	logic [3:0]  bits_q, bits_d;
	logic        level_q, level_d;
	logic        taken;

	always_comb begin
		timer_d = timer_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		level_d = level_q;
		taken   = 1'b0;
		if (timer_q <= 16'd1) begin
			timer_d = bit_time;
			if (bits_q == 4'd0) begin
				if (offer) begin
					shift_d = {1'b1, data};
					level_d = 1'b0;
					bits_d  = TX_BITS;
					taken   = 1'b1;
				end
			end else begin
				level_d = shift_q[0];
				shift_d = {1'b0, shift_q[8:1]};
				bits_d  = bits_q - 4'd1;
			end
		end else begin
			timer_d = timer_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			shift_q <= '0;
			bits_q  <= '0;
			level_q <= 1'b1;
		end else if (step) begin
			timer_q <= timer_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			level_q <= level_d;
		end
	end

	assign res.line  = level_d;
	assign res.taken = taken;

endmodule

// ===== rtl/u8tr_rx.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 receiver
// Edge detect, mid-bit sampling, framing and loss tallies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8tr_rx (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [15:0]      bit_time,
	input  logic             line,
	input  logic             full,
	output u8tr_pkg::rx_res_t res
);
	import u8tr_pkg::*;

	logic [15:0] timer_q, timer_d;
	logic [3:0]  bits_q, bits_d;
	logic [7:0]  shift_q, shift_d;
	logic        prev_q;
	logic [7:0]  no_start_q, no_start_d;
	logic [7:0]  no_stop_q, no_stop_d;
	logic [7:0]  lost_q, lost_d;
	logic        sticky_q, sticky_d;
	logic        got;
	logic [7:0]  got_data;

	always_comb begin
		timer_d    = timer_q;
		bits_d     = bits_q;
		shift_d    = shift_q;
		no_start_d = no_start_q;
		no_stop_d  = no_stop_q;
		lost_d     = lost_q;
		sticky_d   = sticky_q;
		got        = 1'b0;
		got_data   = 8'd0;
		if (bits_q == 4'd0) begin
			if (prev_q && !line) begin
				timer_d = {1'b0, bit_time[15:1]};
				bits_d  = FRAME_BITS;
			end
		end else if (timer_q <= 16'd1) begin
			timer_d = bit_time;
			bits_d  = bits_q - 4'd1;
			if (bits_d == FRAME_BITS - 4'd1) begin
				if (line)
					no_start_d = no_start_q + 8'd1;
			end else if (bits_d != 4'd0) begin
				shift_d = {line, shift_q[7:1]};
			end else begin
				if (!line)
					no_stop_d = no_stop_q + 8'd1;
				if (full) begin
					lost_d   = lost_q + 8'd1;
					sticky_d = 1'b1;
				end else begin
					got      = 1'b1;
					got_data = shift_q;
				end
			end
		end else begin
			timer_d = timer_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q    <= '0;
			bits_q     <= '0;
			shift_q    <= '0;
			prev_q     <= 1'b1;
			no_start_q <= '0;
			no_stop_q  <= '0;
			lost_q     <= '0;
			sticky_q   <= 1'b0;
		end else if (step) begin
			timer_q    <= timer_d;
			bits_q     <= bits_d;
			shift_q    <= shift_d;
			prev_q     <= line;
			no_start_q <= no_start_d;
			no_stop_q  <= no_stop_d;
			lost_q     <= lost_d;
			sticky_q   <= sticky_d;
		end
	end

	assign res.valid     = got;
	assign res.data      = got_data;
	assign res.no_start  = no_start_d;
	assign res.no_stop   = no_stop_d;
	assign res.lost      = lost_d;
	assign res.lost_flag = sticky_d;

endmodule

// ===== rtl/uart_8n1_tx_rx.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 transmitter and receiver
// A request is held in the input register, then its result in the output register.
// Throughput: one request per cycle through the input register and the
// single tick-update stage; output stalls back up into the input register.
// Reset clears all timers, tallies and handshake state; bit time goes to 2500.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_8n1_tx_rx_macros.svh"

module uart_8n1_tx_rx (
	input  logic       clk,
	input  logic       arst_n,
	u8tr_req_if.sink   item,
	u8tr_res_if.source res,
	u8tr_cfg_if.sink   cfg
);
	import u8tr_pkg::*;

	logic [15:0] bit_time_q;
	logic        vld_s1;
	req_t        item_s1;
	logic        vld_s2;
	res_t        res_s2;
	res_t        res_d;
	logic        advance;

	assign cfg.ready  = 1'b1;
	assign advance    = vld_s1 && (!vld_s2 || res.ready);
	assign item.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bit_time_q <= BIT_TIME_RESET;
		else if (cfg.valid)
			bit_time_q <= cfg.bit_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (item.ready)
			vld_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.rx_line       <= item.rx_line;
			item_s1.tx_byte_valid <= item.tx_byte_valid;
			item_s1.tx_byte       <= item.tx_byte;
			item_s1.rx_sink_full  <= item.rx_sink_full;
		end
	end

	u8tr_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.bit_time (bit_time_q),
		.offer    (item_s1.tx_byte_valid),
		.data     (item_s1.tx_byte),
		.res      (res_d.tx)
	);

	u8tr_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.bit_time (bit_time_q),
		.line     (item_s1.rx_line),
		.full     (item_s1.rx_sink_full),
		.res      (res_d.rx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (advance)
			vld_s2 <= 1'b1;
		else if (res.ready)
			vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_d;
	end

	assign res.valid          = vld_s2;
	assign res.tx_line        = res_s2.tx.line;
	assign res.tx_byte_taken  = res_s2.tx.taken;
	assign res.rx_byte_valid  = res_s2.rx.valid;
	assign res.rx_byte        = res_s2.rx.data;
	assign res.no_start_count = res_s2.rx.no_start;
	assign res.no_stop_count  = res_s2.rx.no_stop;
	assign res.lost_count     = res_s2.rx.lost;
	assign res.lost_flag      = res_s2.rx.lost_flag;

	`U8TR_ASSERT_NEXT(a_advance_fills_out, advance, vld_s2, "advance did not fill output")
	`U8TR_ASSERT_NEXT(a_s1_holds, vld_s1 && !advance, vld_s1 && $stable(item_s1), "s1 lost")
	`U8TR_ASSERT_NOW(a_rx_byte_zero, vld_s2 && !res_s2.rx.valid, res_s2.rx.data == 8'd0, "rx byte")

endmodule
